// File: design/kfa_pkg.sv
// Shared types, field widths and codes for the keyframe animation stepper.
package kfa_pkg;

  localparam int TIME_W        = 31;
  localparam int STAMP_W       = 32;
  localparam int SCALE_W       = 16;
  localparam int FRAME_FIELD_W = 10;
  localparam int WEIGHT_W      = 17;
  localparam int PERIOD_W      = 16;
  localparam int FLAGS_W       = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 31;

  localparam int DVD_W   = 64;
  localparam int DSR_W   = 32;
  localparam int QUO_W   = 32;
  localparam int LEN_W   = 7;
  localparam int PROD_W  = 48;
  localparam int SCALED_W = 40;
  localparam int FIDX_W  = 12;

  localparam logic [LEN_W-1:0] DIV_LEN  = 7'd32;
  localparam logic [LEN_W-1:0] MODL_LEN = 7'd40;
  localparam logic [LEN_W-1:0] MODF_LEN = 7'd64;
  localparam logic [LEN_W-1:0] WDIV_LEN = 7'd16;

  localparam logic [STAMP_W-1:0]  LOOKAHEAD_MS = 32'd200;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLAGS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd6;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [SCALE_W-1:0] speed_scale;
  } step_req_t;

  typedef struct packed {
    logic [FRAME_FIELD_W-1:0] shown_frame;
    logic [FRAME_FIELD_W-1:0] earlier_frame;
    logic [WEIGHT_W-1:0]      blend_weight;
    logic                     advanced;
  } pose_req_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [LEN_W-1:0]  len;
    logic [DSR_W-1:0]  divisor;
    logic [DSR_W-1:0]  rem_init;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quotient;
    logic [DSR_W-1:0]  remainder;
  } div_res_t;

  typedef struct packed {
    logic               start;
    logic [QUO_W-1:0]   multiplier;
    logic [SCALE_W-1:0] multiplicand;
  } mul_cmd_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_res_t;

endpackage

// File: design/kfa_stream_if.sv
// Valid/ready stream interface carrying one request payload.
interface kfa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/kfa_serial_div.sv
// Bit-serial restoring divider shared by the frame division, the two modulo steps and the weight division.
module kfa_serial_div (
  input  logic               clk,
  input  logic               rst,
  input  kfa_pkg::div_cmd_t  cmd,
  output kfa_pkg::div_res_t  res
);
  import kfa_pkg::*;

  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [LEN_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DSR_W:0] trial;
  logic [DSR_W:0] diff;
  logic           ge;

  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.len;
        dvd  <= cmd.dividend;
        dsr  <= cmd.divisor;
        rem  <= cmd.rem_init;
        quo  <= '0;
      end else if (busy) begin
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        rem <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        quo <= {quo[QUO_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == LEN_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;
endmodule

// File: design/kfa_serial_mul.sv
// Shift-add multiplier taking one multiplier bit per cycle.
module kfa_serial_mul (
  input  logic               clk,
  input  logic               rst,
  input  kfa_pkg::mul_cmd_t  cmd,
  output kfa_pkg::mul_res_t  res
);
  import kfa_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [SCALE_W-1:0] mcand;
  logic [SCALE_W-1:0] hi;
  logic [QUO_W-1:0]   lo;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [SCALE_W:0]   sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(QUO_W - 1);
        mcand <= cmd.multiplicand;
        hi    <= '0;
        lo    <= cmd.multiplier;
      end else if (busy) begin
        hi  <= sum[SCALE_W:1];
        lo  <= {sum[0], lo[QUO_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done    = done;
  assign res.product = {hi, lo};
endmodule

// File: design/keyframe_animation_stepper.sv
// Top level of the keyframe animation stepper: registers, sequencer and frame state.
//
//   Channel  Role    Payload
//   step     input   now_ms, speed_scale
//   pose     output  shown_frame, earlier_frame, blend_weight, advanced
//   cfg_*    write   seven registers, index 0 to 6
//
// One request is worked on at a time; step.ready is high only while the sequencer is idle.
// A disabled or zero-period request goes straight to the done state, a step without a
// frame change runs the clamp and weight states and may use the serial divider for the
// weight, and a frame change also runs the serial multiplier and uses the divider for
// the frame offset and the two modulo steps. The result sits in an output register, so
// the next request is taken while it waits. Reset is synchronous.
module keyframe_animation_stepper #(
  parameter int FRAME_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kfa_pkg::CFG_DATA_W-1:0] cfg_data,
  kfa_stream_if.sink                     step,
  kfa_stream_if.source                   pose
);
  import kfa_pkg::*;

  localparam int EW = (FRAME_BITS > FIDX_W) ? FRAME_BITS : FIDX_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_DSET   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_RANGE  = 4'd5;
  localparam logic [3:0] S_MODL   = 4'd6;
  localparam logic [3:0] S_PICK   = 4'd7;
  localparam logic [3:0] S_MODF   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_CLAMP  = 4'd10;
  localparam logic [3:0] S_WSET   = 4'd11;
  localparam logic [3:0] S_WCMP   = 4'd12;
  localparam logic [3:0] S_WDIV   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic                     anim_enable;
  logic [FRAME_FIELD_W-1:0] first_frame;
  logic [FRAME_FIELD_W-1:0] frame_count;
  logic [FRAME_FIELD_W-1:0] loop_count;
  logic [PERIOD_W-1:0]      frame_period;
  logic [FLAGS_W-1:0]       play_flags;
  logic [TIME_W-1:0]        seq_start_time;

  logic [3:0]            state;
  logic [TIME_W-1:0]     now_r;
  logic [SCALE_W-1:0]    scale_r;
  logic [FRAME_BITS-1:0] cur_frame;
  logic [FRAME_BITS-1:0] prev_frame;
  logic [STAMP_W-1:0]    next_time;
  logic [STAMP_W-1:0]    prev_time;
  logic [STAMP_W-1:0]    ft_r;
  logic [STAMP_W-1:0]    num_r;
  logic [STAMP_W-1:0]    den_r;
  logic signed [FIDX_W-1:0] f_r;
  logic [WEIGHT_W-1:0]   weight_r;
  logic                  adv_r;
  logic                  pose_valid;
  pose_req_t             pose_data;

  div_cmd_t div_cmd;
  div_res_t div_res;
  mul_cmd_t mul_cmd;
  mul_res_t mul_res;

  logic [STAMP_W-1:0]    now_w;
  logic [STAMP_W-1:0]    now_la;
  logic [STAMP_W:0]      diff33;
  logic                  diff_pos;
  logic [SCALED_W-1:0]   p40;
  logic [FRAME_FIELD_W:0] nf11;
  logic                  p_ge;
  logic [SCALED_W-1:0]   p2;
  logic                  flip_hit;
  logic [EW-1:0]         first_e;
  logic [EW-1:0]         base_e;
  logic [EW-1:0]         f_e;
  logic [EW-1:0]         rem_e;
  logic [EW-1:0]         rev_frame;
  logic [EW-1:0]         fwd_frame;
  logic [EW-1:0]         modf_frame;

  kfa_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .res (div_res)
  );

  kfa_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .cmd (mul_cmd),
    .res (mul_res)
  );

  assign now_w    = {1'b0, now_r};
  assign now_la   = now_w + LOOKAHEAD_MS;
  assign diff33   = {1'b0, ft_r} - {2'b0, seq_start_time};
  assign diff_pos = !diff33[STAMP_W] && (diff33 != '0);
  assign p40      = mul_res.product[PROD_W-1:PROD_W-SCALED_W];
  assign nf11     = play_flags[1] ? {frame_count, 1'b0} : {1'b0, frame_count};
  assign p_ge     = p40 >= SCALED_W'(nf11);
  assign p2       = p40 - SCALED_W'(nf11);
  assign flip_hit = f_r[FIDX_W-1] || (f_r[FIDX_W-2:0] >= {1'b0, frame_count});

  assign first_e    = EW'(first_frame);
  assign base_e     = first_e + EW'(frame_count) - EW'(1);
  assign f_e        = EW'(f_r);
  assign rem_e      = EW'(div_res.remainder[FRAME_FIELD_W-1:0]);
  assign rev_frame  = base_e - f_e;
  assign fwd_frame  = first_e + f_e;
  assign modf_frame = base_e - rem_e;

  always_comb begin
    div_cmd = '0;
    case (state)
      S_DSET: begin
        div_cmd.start    = 1'b1;
        div_cmd.dividend = {(diff_pos ? diff33[STAMP_W-1:0] : '0), {(DVD_W-STAMP_W){1'b0}}};
        div_cmd.len      = DIV_LEN;
        div_cmd.divisor  = DSR_W'(frame_period);
      end
      S_RANGE: begin
        if (p_ge && loop_count != '0) begin
          div_cmd.start    = 1'b1;
          div_cmd.dividend = {p2, {(DVD_W-SCALED_W){1'b0}}};
          div_cmd.len      = MODL_LEN;
          div_cmd.divisor  = DSR_W'(loop_count);
        end
      end
      S_PICK: begin
        if (!play_flags[0] && play_flags[1] && flip_hit && frame_count != '0) begin
          div_cmd.start    = 1'b1;
          div_cmd.dividend = DVD_W'(f_r);
          div_cmd.len      = MODF_LEN;
          div_cmd.divisor  = DSR_W'(frame_count);
        end
      end
      S_WCMP: begin
        if (num_r != '0 && num_r < den_r) begin
          div_cmd.start    = 1'b1;
          div_cmd.len      = WDIV_LEN;
          div_cmd.divisor  = den_r;
          div_cmd.rem_init = num_r;
        end
      end
      default: begin
        div_cmd = '0;
      end
    endcase
  end

  always_comb begin
    mul_cmd.start        = (state == S_DIV) && div_res.done;
    mul_cmd.multiplier   = div_res.quotient;
    mul_cmd.multiplicand = scale_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_enable    <= 1'b1;
      first_frame    <= '0;
      frame_count    <= FRAME_FIELD_W'(1);
      loop_count     <= '0;
      frame_period   <= '0;
      play_flags     <= '0;
      seq_start_time <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE: anim_enable    <= cfg_data[0];
        REG_FIRST:  first_frame    <= cfg_data[FRAME_FIELD_W-1:0];
        REG_COUNT:  frame_count    <= cfg_data[FRAME_FIELD_W-1:0];
        REG_LOOP:   loop_count     <= cfg_data[FRAME_FIELD_W-1:0];
        REG_PERIOD: frame_period   <= cfg_data[PERIOD_W-1:0];
        REG_FLAGS:  play_flags     <= cfg_data[FLAGS_W-1:0];
        REG_START:  seq_start_time <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_frame  <= '0;
      prev_frame <= '0;
      next_time  <= '0;
      prev_time  <= '0;
      pose_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!pose_valid || pose.ready)) begin
        pose_valid              <= 1'b1;
        pose_data.shown_frame   <= FRAME_FIELD_W'(cur_frame);
        pose_data.earlier_frame <= FRAME_FIELD_W'(prev_frame);
        pose_data.blend_weight  <= weight_r;
        pose_data.advanced      <= adv_r;
      end else if (pose.ready) begin
        pose_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (step.valid) begin
            now_r   <= step.data.now_ms;
            scale_r <= step.data.speed_scale;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          weight_r <= '0;
          adv_r    <= 1'b0;
          if (!anim_enable) begin
            cur_frame  <= '0;
            prev_frame <= '0;
            state      <= S_DONE;
          end else if (now_w >= next_time) begin
            prev_frame <= cur_frame;
            prev_time  <= next_time;
            if (frame_period == '0) begin
              state <= S_DONE;
            end else begin
              adv_r <= 1'b1;
              ft_r  <= (now_r < seq_start_time) ? {1'b0, seq_start_time}
                                                : next_time + STAMP_W'(frame_period);
              state <= S_DSET;
            end
          end else begin
            state <= S_CLAMP;
          end
        end
        S_DSET: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_res.done) begin
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (p_ge) begin
            if (loop_count != '0) begin
              state <= S_MODL;
            end else begin
              f_r   <= {1'b0, nf11} - FIDX_W'(1);
              ft_r  <= now_w;
              state <= S_PICK;
            end
          end else begin
            f_r   <= p40[FIDX_W-1:0];
            state <= S_PICK;
          end
        end
        S_MODL: begin
          if (div_res.done) begin
            f_r   <= {2'b0, div_res.remainder[FRAME_FIELD_W-1:0]}
                     + {2'b0, frame_count} - {2'b0, loop_count};
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (play_flags[0]) begin
            cur_frame <= rev_frame[FRAME_BITS-1:0];
            state     <= S_FIN;
          end else if (play_flags[1] && flip_hit) begin
            if (frame_count == '0) begin
              cur_frame <= base_e[FRAME_BITS-1:0];
              state     <= S_FIN;
            end else begin
              state <= S_MODF;
            end
          end else begin
            cur_frame <= fwd_frame[FRAME_BITS-1:0];
            state     <= S_FIN;
          end
        end
        S_MODF: begin
          if (div_res.done) begin
            cur_frame <= modf_frame[FRAME_BITS-1:0];
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          next_time <= (ft_r < now_w) ? now_w : ft_r;
          state     <= S_CLAMP;
        end
        S_CLAMP: begin
          if (next_time > now_la) begin
            next_time <= now_w;
          end
          if (prev_time > now_w) begin
            prev_time <= now_w;
          end
          state <= S_WSET;
        end
        S_WSET: begin
          if (next_time == prev_time) begin
            state <= S_DONE;
          end else begin
            num_r <= now_w - prev_time;
            den_r <= next_time - prev_time;
            state <= S_WCMP;
          end
        end
        S_WCMP: begin
          if (num_r == '0) begin
            weight_r <= WEIGHT_ONE;
            state    <= S_DONE;
          end else if (num_r >= den_r) begin
            weight_r <= '0;
            state    <= S_DONE;
          end else begin
            state <= S_WDIV;
          end
        end
        S_WDIV: begin
          if (div_res.done) begin
            weight_r <= WEIGHT_ONE - WEIGHT_W'(div_res.quotient[WDIV_LEN-1:0]);
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!pose_valid || pose.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign step.ready = (state == S_IDLE);
  assign pose.valid = pose_valid;
  assign pose.data  = pose_data;
endmodule

// File: dv/kfa_pose_checker.sv
// Checker for the keyframe animation stepper: predicts each pose and compares it on arrival.
`timescale 1ns / 1ps

module kfa_pose_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           step_valid,
  input  logic                           step_ready,
  input  kfa_pkg::step_req_t             step_data,
  input  logic                           pose_valid,
  input  logic                           pose_ready,
  input  kfa_pkg::pose_req_t             pose_data,
  output int                             mismatch_count,
  output int                             poses_waiting
);
  import kfa_pkg::*;

  localparam int REVERSE_BIT = 0;
  localparam int FLIP_BIT    = 1;

  logic                     anim_en;
  logic [FRAME_FIELD_W-1:0] first_r;
  logic [FRAME_FIELD_W-1:0] count_r;
  logic [FRAME_FIELD_W-1:0] loop_r;
  logic [PERIOD_W-1:0]      period_r;
  logic [FLAGS_W-1:0]       flags_r;
  logic [TIME_W-1:0]        start_r;

  logic [FRAME_FIELD_W-1:0] cur_f;
  logic [FRAME_FIELD_W-1:0] prev_f;
  logic [STAMP_W-1:0]       next_t;
  logic [STAMP_W-1:0]       prev_t;

  pose_req_t expected_poses[$];
  pose_req_t oldest_pose;
  int        fails;
  int        poses_seen;

  function automatic pose_req_t predict_pose(input step_req_t req);
    logic [63:0]    now;
    logic [63:0]    scale;
    logic [63:0]    ft;
    logic [63:0]    f;
    logic [63:0]    nf;
    logic [63:0]    rem;
    logic [63:0]    pick;
    logic [63:0]    weight;
    longint         diff;
    longint         num;
    longint         den;
    pose_req_t      p;
    now    = 64'(req.now_ms);
    scale  = 64'(req.speed_scale);
    weight = '0;
    p      = '0;
    if (!anim_en) begin
      cur_f  = '0;
      prev_f = '0;
      return p;
    end
    if (now >= 64'(next_t)) begin
      prev_f = cur_f;
      prev_t = next_t;
      if (period_r == '0) begin
        p.shown_frame   = cur_f;
        p.earlier_frame = prev_f;
        return p;
      end
      p.advanced = 1'b1;
      if (now < 64'(start_r)) ft = 64'(start_r);
      else ft = 64'(prev_t) + 64'(period_r);
      diff = longint'(ft) - longint'(64'(start_r));
      f = (diff > 0) ? 64'(diff) / 64'(period_r) : 64'd0;
      f = (f * scale) >> 8;
      nf = 64'(count_r);
      if (flags_r[FLIP_BIT]) nf = nf * 64'd2;
      if (f >= nf) begin
        f = f - nf;
        if (loop_r != '0) begin
          f = f % 64'(loop_r);
          f = f + 64'(count_r) - 64'(loop_r);
        end else begin
          f  = nf - 64'd1;
          ft = now;
        end
      end
      if (flags_r[REVERSE_BIT]) begin
        pick = 64'(first_r) + 64'(count_r) - 64'd1 - f;
      end else if (flags_r[FLIP_BIT] && f >= 64'(count_r)) begin
        rem  = (count_r != '0) ? f % 64'(count_r) : 64'd0;
        pick = 64'(first_r) + 64'(count_r) - 64'd1 - rem;
      end else begin
        pick = 64'(first_r) + f;
      end
      cur_f = pick[FRAME_FIELD_W-1:0];
      if (now > ft) ft = now;
      next_t = ft[STAMP_W-1:0];
    end
    if (64'(next_t) > now + 64'(LOOKAHEAD_MS)) next_t = now[STAMP_W-1:0];
    if (64'(prev_t) > now) prev_t = now[STAMP_W-1:0];
    if (next_t != prev_t) begin
      num = longint'(now) - longint'(64'(prev_t));
      den = longint'(64'(next_t)) - longint'(64'(prev_t));
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num <= 0) begin
        weight = 64'(WEIGHT_ONE);
      end else if (num >= den) begin
        weight = 64'd0;
      end else begin
        weight = 64'(WEIGHT_ONE) - (64'(num) * 64'(WEIGHT_ONE)) / 64'(den);
      end
    end
    p.shown_frame   = cur_f;
    p.earlier_frame = prev_f;
    p.blend_weight  = weight[WEIGHT_W-1:0];
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      anim_en    = 1'b1;
      first_r    = '0;
      count_r    = FRAME_FIELD_W'(1);
      loop_r     = '0;
      period_r   = '0;
      flags_r    = '0;
      start_r    = '0;
      cur_f      = '0;
      prev_f     = '0;
      next_t     = '0;
      prev_t     = '0;
      fails      = 0;
      poses_seen = 0;
      expected_poses.delete();
      mismatch_count <= 0;
      poses_waiting  <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ENABLE: anim_en  = cfg_data[0];
          REG_FIRST:  first_r  = cfg_data[FRAME_FIELD_W-1:0];
          REG_COUNT:  count_r  = cfg_data[FRAME_FIELD_W-1:0];
          REG_LOOP:   loop_r   = cfg_data[FRAME_FIELD_W-1:0];
          REG_PERIOD: period_r = cfg_data[PERIOD_W-1:0];
          REG_FLAGS:  flags_r  = cfg_data[FLAGS_W-1:0];
          REG_START:  start_r  = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (pose_valid && pose_ready) begin
        poses_seen++;
        if (expected_poses.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("pose %0d arrived with no request waiting: %s %0d %s %0d %s %0d %s %0d",
                     poses_seen, "shown", pose_data.shown_frame,
                     "earlier", pose_data.earlier_frame,
                     "weight", pose_data.blend_weight, "adv", pose_data.advanced);
          end
        end else begin
          oldest_pose = expected_poses.pop_front();
          if (oldest_pose.shown_frame !== pose_data.shown_frame ||
              oldest_pose.earlier_frame !== pose_data.earlier_frame ||
              oldest_pose.blend_weight !== pose_data.blend_weight ||
              oldest_pose.advanced !== pose_data.advanced) begin
            fails++;
            if (fails <= 10) begin
              $display("pose %0d: expected shown %0d earlier %0d weight %0d adv %0d,",
                       poses_seen, oldest_pose.shown_frame, oldest_pose.earlier_frame,
                       oldest_pose.blend_weight, oldest_pose.advanced);
              $display("  got shown %0d earlier %0d weight %0d adv %0d",
                       pose_data.shown_frame, pose_data.earlier_frame,
                       pose_data.blend_weight, pose_data.advanced);
            end
          end
        end
      end
      if (step_valid && step_ready) expected_poses.push_back(predict_pose(step_data));
      mismatch_count <= fails;
      poses_waiting  <= expected_poses.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for the keyframe animation stepper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import kfa_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  localparam logic [FLAGS_W-1:0] PLAY_FORWARD  = 2'd0;
  localparam logic [FLAGS_W-1:0] PLAY_REVERSE  = 2'd1;
  localparam logic [FLAGS_W-1:0] PLAY_FLIP     = 2'd2;
  localparam logic [FLAGS_W-1:0] PLAY_REV_FLIP = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int poses_waiting;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  kfa_stream_if #(.T(step_req_t)) step_ch ();
  kfa_stream_if #(.T(pose_req_t)) pose_ch ();

  keyframe_animation_stepper uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step_ch),
    .pose      (pose_ch)
  );

  kfa_pose_checker pose_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .step_valid     (step_ch.valid),
    .step_ready     (step_ch.ready),
    .step_data      (step_ch.data),
    .pose_valid     (pose_ch.valid),
    .pose_ready     (pose_ch.ready),
    .pose_data      (pose_ch.data),
    .mismatch_count (mismatch_count),
    .poses_waiting  (poses_waiting)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    pose_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      pose_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_step(input logic [TIME_W-1:0] now, input logic [SCALE_W-1:0] scale);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      step_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    step_ch.valid <= 1'b1;
    step_ch.data  <= '{now_ms: now, speed_scale: scale};
    do @(posedge clk); while (!step_ch.ready);
  endtask

  task automatic wait_for_poses();
    step_ch.valid <= 1'b0;
    do @(posedge clk); while (poses_waiting != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic en, input logic [FRAME_FIELD_W-1:0] first,
                              input logic [FRAME_FIELD_W-1:0] count,
                              input logic [FRAME_FIELD_W-1:0] loop_n,
                              input logic [PERIOD_W-1:0] period,
                              input logic [FLAGS_W-1:0] flags,
                              input logic [TIME_W-1:0] start);
    wait_for_poses();
    write_reg(REG_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_FIRST, CFG_DATA_W'(first));
    write_reg(REG_COUNT, CFG_DATA_W'(count));
    write_reg(REG_LOOP, CFG_DATA_W'(loop_n));
    write_reg(REG_PERIOD, CFG_DATA_W'(period));
    write_reg(REG_FLAGS, CFG_DATA_W'(flags));
    write_reg(REG_START, CFG_DATA_W'(start));
    cfg_write <= 1'b0;
  endtask

  logic                     r_en;
  logic [FRAME_FIELD_W-1:0] r_first;
  logic [FRAME_FIELD_W-1:0] r_count;
  logic [FRAME_FIELD_W-1:0] r_loop;
  logic [PERIOD_W-1:0]      r_period;
  logic [FLAGS_W-1:0]       r_flags;
  logic [TIME_W-1:0]        r_start;
  logic [TIME_W-1:0]        t_ms;
  logic [SCALE_W-1:0]       r_scale;
  int                       span;
  int                       pick;

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    step_ch.valid = 1'b0;
    step_ch.data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero period, so every request lands on a frame boundary.
    send_step(31'd0, 16'd0);
    send_step(31'h7FFF_FFFF, 16'hFFFF);

    // Before the start, through the sequence, and past its end into the loop.
    program_regs(1'b1, 10'd0, 10'd4, 10'd2, 16'd10, PLAY_FORWARD, 31'd100);
    send_step(31'd50, 16'd256);
    send_step(31'd100, 16'd256);
    send_step(31'd105, 16'd256);
    send_step(31'd112, 16'd256);
    send_step(31'd135, 16'd256);
    send_step(31'd150, 16'd256);
    send_step(31'd170, 16'd512);
    send_step(31'd171, 16'd0);

    // Zero frame count with reversed flip-flop playback.
    program_regs(1'b1, 10'd5, 10'd0, 10'd0, 16'd7, PLAY_REV_FLIP, 31'd0);
    send_step(31'd10, 16'd256);
    send_step(31'd20, 16'd256);
    send_step(31'd40, 16'd256);

    program_regs(1'b1, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, PLAY_FLIP, 31'h7FFF_FFFF);
    send_step(31'h7FFF_FFFF, 16'hFFFF);
    send_step(31'd0, 16'd256);

    // Loop count above frame count under flip-flop playback.
    program_regs(1'b1, 10'd3, 10'd5, 10'd9, 16'd1, PLAY_FLIP, 31'd20);
    send_step(31'd30, 16'd2560);
    send_step(31'd31, 16'hFFFF);

    // Past the end with no loop: the last frame is held.
    program_regs(1'b1, 10'd0, 10'd3, 10'd0, 16'd1, PLAY_REVERSE, 31'd0);
    send_step(31'd100, 16'd256);
    send_step(31'd101, 16'd256);

    program_regs(1'b0, 10'd0, 10'd4, 10'd1, 16'd5, PLAY_FORWARD, 31'd0);
    send_step(31'd500, 16'd256);

    program_regs(1'b1, 10'd0, 10'd4, 10'd1, 16'd0, PLAY_FORWARD, 31'd0);
    send_step(31'd1000, 16'd256);

    t_ms = 31'd1000;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int seg = 0; seg < 10; seg++) begin
        if ($urandom_range(0, 3) == 0) t_ms = TIME_W'($urandom);
        r_en    = ($urandom_range(0, 15) != 0);
        r_first = FRAME_FIELD_W'($urandom_range(0, 1023));
        pick = $urandom_range(0, 15);
        if (pick < 12) r_count = FRAME_FIELD_W'($urandom_range(1, 12));
        else if (pick < 14) r_count = FRAME_FIELD_W'($urandom_range(1, 1023));
        else if (pick == 14) r_count = 10'd1023;
        else r_count = 10'd0;
        pick = $urandom_range(0, 7);
        if (pick < 5) r_loop = FRAME_FIELD_W'($urandom_range(0, r_count));
        else if (pick < 7) r_loop = 10'd0;
        else r_loop = FRAME_FIELD_W'($urandom_range(0, 1023));
        pick = $urandom_range(0, 15);
        if (pick < 12) r_period = PERIOD_W'($urandom_range(1, 40));
        else if (pick < 13) r_period = 16'd0;
        else if (pick < 14) r_period = 16'hFFFF;
        else r_period = PERIOD_W'($urandom_range(0, 65535));
        r_flags = FLAGS_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 3);
        if (pick == 0) r_start = t_ms;
        else if (pick == 1) r_start = t_ms + TIME_W'($urandom_range(0, 300));
        else if (pick == 2) r_start = t_ms - TIME_W'($urandom_range(0, 2000));
        else r_start = TIME_W'($urandom);
        program_regs(r_en, r_first, r_count, r_loop, r_period, r_flags, r_start);

        span = (r_period == 0) ? 50 : ((r_period > 300) ? 300 : int'(r_period)) + 5;
        for (int n = 0; n < 46; n++) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) t_ms = t_ms + TIME_W'($urandom_range(0, span));
          else if (pick < 80) t_ms = t_ms + TIME_W'($urandom_range(0, 400));
          else if (pick < 88) t_ms = t_ms - TIME_W'($urandom_range(0, 300));
          else if (pick < 94) t_ms = TIME_W'($urandom);
          pick = $urandom_range(0, 99);
          if (pick < 60) r_scale = 16'd256;
          else if (pick < 80) r_scale = SCALE_W'($urandom_range(0, 1024));
          else r_scale = SCALE_W'($urandom_range(0, 65535));
          send_step(t_ms, r_scale);
        end
      end
    end

    wait_for_poses();
    repeat (250) @(posedge clk);
    if (mismatch_count == 0 && poses_waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
